@@ hdl/pmqs_pkg.sv @@
// Package for the priority message queue scheduler.
// Holds payload structs, op/status codes, slot count and FSM state type; no dependencies.
package pmqs_pkg;

    // message slots; matches the 5-bit handle fields
    localparam int MESSAGE_SLOTS = 32;

    typedef enum logic [1:0] {
        OP_POST     = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_REMOVE   = 2'd2
    } t_op;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ID  = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;

    localparam logic CFG_TASK_COUNT = 1'b0;
    localparam logic CFG_PRIO_MAP   = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] task_id;
        logic [7:0] sig;
        logic [4:0] msg_handle;
        logic [3:0] current_level;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] out_handle;
        logic [2:0] out_task;
        logic [7:0] out_sig;
        logic [3:0] out_priority;
        logic [5:0] removed_count;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WALK,
        S_EMIT,
        S_FINAL
    } t_state;

endpackage

@@ hdl/priority_message_queue_scheduler.sv @@
// Priority message queue scheduler: per-level linked FIFOs of message slots.
// A rejected item (bad task id, nothing ready, empty remove) loads its result at
// the accepting edge; a post to an empty level loads it in S_FINAL after
// S_READ, a post to a non-empty level or a dispatch after S_READ and S_WALK
// (slot RAM read, then write-back). The input stalls while a result waits, so
// the next item is taken the cycle after the result transfer. A remove walks
// the queue through S_READ and S_WALK per slot (RAM read latency), with an
// S_EMIT result per removed slot and an S_FINAL result with the count. Queue
// heads, tails and the ready bitmap sit in flip-flops (8 entries); slot links
// sit in one RAM, tasks and signals in another. Depends on pmqs_pkg and pmqs_ram.
module priority_message_queue_scheduler #(
    parameter int PRIORITY_LEVELS = 8,
    parameter int TASK_LIMIT      = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  pmqs_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output pmqs_pkg::t_out_item  o_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [23:0]          i_cfg_data
);
    import pmqs_pkg::*;

    localparam int SW = $clog2(MESSAGE_SLOTS);
    localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int DW = 3 + 8;

    // configuration registers; always writable
    logic [3:0]  r_task_count;
    logic [23:0] r_prio_map;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= '0;
            r_prio_map   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TASK_COUNT: r_task_count <= i_cfg_data[3:0];
                CFG_PRIO_MAP:   r_prio_map   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // queue state
    logic [PRIORITY_LEVELS-1:0] r_ready, n_ready;
    logic [SW-1:0] r_head [PRIORITY_LEVELS];
    logic [SW-1:0] r_tail [PRIORITY_LEVELS];
    logic          head_we, tail_we;
    logic [SW-1:0] head_wd, tail_wd;

    // item registers
    t_state        r_state, n_state;
    t_in_item      r_in;
    logic [LW-1:0] r_lv, n_lv;
    logic [SW-1:0] r_cur, n_cur, r_prev, n_prev, r_hd, n_hd;
    logic          r_have_prev, n_have_prev;
    logic [6:0]    r_steps, n_steps;
    logic [5:0]    r_removed, n_removed;
    logic          r_ovalid, n_ovalid;
    t_out_item     r_out, n_out;

    // slot RAMs: links in one, {task, signal} in the other, shared read address
    logic          next_we, data_we;
    logic [SW-1:0] next_waddr, data_waddr, ram_raddr;
    logic [SW-1:0] next_wdata;
    logic [DW-1:0] data_wdata, data_rdata;
    logic [SW-1:0] rd_next;
    logic [2:0]    rd_task;
    logic [7:0]    rd_sig;

    pmqs_ram #(.WIDTH(SW), .DEPTH(MESSAGE_SLOTS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_next)
    );

    pmqs_ram #(.WIDTH(DW), .DEPTH(MESSAGE_SLOTS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (data_rdata)
    );
    assign {rd_task, rd_sig} = data_rdata;

    // decode of the incoming item
    logic          out_free, acc;
    logic          in_valid_id;
    logic [2:0]    map_lv;
    logic [LW-1:0] in_lv;
    logic [SW-1:0] in_hd;
    logic [3:0]    top;
    logic [LW-1:0] top_lv;

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || r_ovalid;
    assign acc      = i_valid && !o_stall;
    assign in_valid_id = ({1'b0, i_item.task_id} < r_task_count)
                      && (32'(i_item.task_id) < TASK_LIMIT);
    assign map_lv = r_prio_map[3 * i_item.task_id +: 3];
    assign in_lv  = (32'(map_lv) >= PRIORITY_LEVELS) ? LW'(PRIORITY_LEVELS - 1) : LW'(map_lv);
    assign in_hd  = SW'(i_item.msg_handle % MESSAGE_SLOTS);

    always_comb begin
        top = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (r_ready[i]) top = 4'(i + 1);
        end
        top_lv = LW'(top - 4'd1);
    end

    // walk helpers
    logic is_last, match;
    assign is_last = (r_cur == r_tail[r_lv]);
    assign match   = (rd_task == r_in.task_id) && (rd_sig == r_in.sig);

    always_comb begin
        n_state = r_state; n_lv = r_lv; n_cur = r_cur; n_prev = r_prev;
        n_hd = r_hd; n_have_prev = r_have_prev; n_steps = r_steps;
        n_removed = r_removed; n_ready = r_ready;
        n_ovalid = r_ovalid && i_stall; n_out = r_out;
        next_we = 1'b0; next_waddr = '0; next_wdata = '0;
        data_we = 1'b0; data_waddr = '0; data_wdata = '0;
        ram_raddr = r_cur;
        head_we = 1'b0; head_wd = '0; tail_we = 1'b0; tail_wd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_hd = in_hd; n_lv = in_lv;
                    n_out = '0; n_out.last = 1'b1;
                    case (i_item.op)
                        OP_POST: begin
                            if (!in_valid_id) begin
                                n_out.status = ST_BAD_ID; n_ovalid = 1'b1;
                            end else begin
                                // write slot task/signal; its link stays as it is
                                data_we = 1'b1; data_waddr = in_hd;
                                data_wdata = {i_item.task_id, i_item.sig};
                                n_cur = r_tail[in_lv];
                                n_state = S_READ;
                            end
                        end
                        OP_DISPATCH: begin
                            if (top == 4'd0 || top <= i_item.current_level) begin
                                n_out.status = ST_NONE; n_ovalid = 1'b1;
                            end else begin
                                n_lv = top_lv; n_cur = r_head[top_lv];
                                n_state = S_READ;
                            end
                        end
                        OP_REMOVE: begin
                            if (!in_valid_id) begin
                                n_out.status = ST_BAD_ID; n_ovalid = 1'b1;
                            end else if (!r_ready[in_lv]) begin
                                n_out.status = ST_NONE; n_ovalid = 1'b1;
                            end else begin
                                n_cur = r_head[in_lv]; n_have_prev = 1'b0;
                                n_steps = '0; n_removed = '0;
                                n_state = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                // address r_cur presented; data valid next cycle
                ram_raddr = r_cur;
                n_state = (r_in.op == OP_POST) ? S_EMIT : S_WALK;
                if (r_in.op == OP_POST) begin
                    if (r_ready[r_lv]) begin
                        // link behind the old tail
                        n_state = S_WALK;
                    end else begin
                        head_we = 1'b1; head_wd = r_hd;
                        tail_we = 1'b1; tail_wd = r_hd;
                        n_ready[r_lv] = 1'b1;
                        n_out.out_handle = 5'(r_hd); n_out.out_task = r_in.task_id;
                        n_out.out_sig = r_in.sig; n_out.out_priority = 4'(r_lv) + 4'd1;
                        n_state = S_FINAL;
                    end
                end
            end
            S_WALK: begin
                if (r_in.op == OP_POST) begin
                    next_we = 1'b1; next_waddr = r_cur; next_wdata = r_hd;
                    tail_we = 1'b1; tail_wd = r_hd;
                    n_out.out_handle = 5'(r_hd); n_out.out_task = r_in.task_id;
                    n_out.out_sig = r_in.sig; n_out.out_priority = 4'(r_lv) + 4'd1;
                    n_state = S_FINAL;
                end else if (r_in.op == OP_DISPATCH) begin
                    if (is_last) n_ready[r_lv] = 1'b0;
                    else begin head_we = 1'b1; head_wd = rd_next; end
                    n_out.out_handle = 5'(r_cur); n_out.out_task = rd_task;
                    n_out.out_sig = rd_sig; n_out.out_priority = 4'(r_lv) + 4'd1;
                    n_state = S_FINAL;
                end else begin
                    n_steps = r_steps + 7'd1;
                    n_cur = rd_next;
                    if (match) begin
                        if (!r_have_prev) begin head_we = 1'b1; head_wd = rd_next; end
                        else begin
                            // relink prev past the removed slot
                            next_we = 1'b1; next_waddr = r_prev; next_wdata = rd_next;
                        end
                        if (is_last) begin
                            if (r_have_prev) begin tail_we = 1'b1; tail_wd = r_prev; end
                            else n_ready[r_lv] = 1'b0;
                        end
                        n_removed = r_removed + 6'd1;
                        n_hd = r_cur;
                        n_state = S_EMIT;
                    end else begin
                        n_prev = r_cur; n_have_prev = 1'b1;
                        n_state = (is_last || 32'(r_steps) + 1 >= MESSAGE_SLOTS)
                                ? S_FINAL : S_READ;
                    end
                    if (is_last) n_steps = 7'(MESSAGE_SLOTS);
                end
            end
            S_EMIT: begin
                // one result per removed slot, once the result register is free
                if (out_free) begin
                    n_out = '0; n_out.out_handle = 5'(r_hd);
                    n_out.removed_count = r_removed;
                    n_ovalid = 1'b1;
                    n_state = (32'(r_steps) >= MESSAGE_SLOTS || r_removed >= 6'd32)
                            ? S_FINAL : S_READ;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    if (r_in.op == OP_REMOVE) begin
                        n_out = '0; n_out.last = 1'b1;
                        n_out.removed_count = r_removed;
                        n_out.status = (r_removed != '0) ? ST_OK : ST_NONE;
                    end else begin
                        n_out.last = 1'b1; n_out.status = ST_OK;
                    end
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, ready bitmap and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ready  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ready  <= n_ready;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_in <= i_item;
        r_lv <= n_lv; r_cur <= n_cur; r_prev <= n_prev; r_hd <= n_hd;
        r_have_prev <= n_have_prev; r_steps <= n_steps;
        r_removed <= n_removed; r_out <= n_out;
        if (head_we) r_head[r_lv] <= head_wd;
        if (tail_we) r_tail[r_lv] <= tail_wd;
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    // the input is stalled whenever the FSM is not idle
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_item)) else $error("stalled result changed");
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_removed != '0)) else $error("emit with zero count");
endmodule

@@ hdl/pmqs_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data; no dependencies.
module pmqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
